// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on clk_i and
// is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define SCCE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Checks that a condition never holds outside reset.
`define SCCE_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

// File: rtl/scce_pkg.sv
// ----------------------------------------------------------------------------
// scce_pkg
// Types and constants of the cooktop panel command emitter.
// ----------------------------------------------------------------------------
package scce_pkg;

  localparam int unsigned BURNER_COUNT = 4;
  localparam int unsigned MAX_BURNERS  = 4;
  localparam int unsigned NUM_BURNERS  =
      (BURNER_COUNT < MAX_BURNERS) ? BURNER_COUNT : MAX_BURNERS;
  localparam int unsigned OVEN_BIT     = 4;

  typedef enum logic [1:0] {
    KIND_BURNER = 2'd0,
    KIND_OVEN   = 2'd1,
    KIND_FAN    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ACT_ON   = 3'd0,
    ACT_OFF  = 3'd1,
    ACT_TEMP = 3'd2,
    ACT_FUNC = 3'd3,
    ACT_FAN  = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEDGE,
    ST_BTEMP,
    ST_OVEN_EDGE,
    ST_SEQ_FUNC,
    ST_SEQ_TEMP,
    ST_OVEN_FUNC,
    ST_OVEN_TEMP,
    ST_FAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [4:0] enable_switches;
    logic [2:0] burner_level;
    logic [2:0] oven_mode;
    logic [2:0] oven_level;
    logic [2:0] fan_level;
  } sample_t;

  typedef struct packed {
    kind_e      target_kind;
    logic [1:0] unit_index;
    action_e    action;
    logic [2:0] value;
    logic       last_of_run;
  } cmd_t;

endpackage

// File: rtl/scce_if.sv
// ----------------------------------------------------------------------------
// scce_if
// Valid/ready channels for panel samples and for device commands.
// ----------------------------------------------------------------------------
interface scce_sample_if;
  logic       valid;
  logic       ready;
  logic [4:0] enable_switches;
  logic [2:0] burner_level;
  logic [2:0] oven_mode;
  logic [2:0] oven_level;
  logic [2:0] fan_level;

  modport source (output valid, output enable_switches, output burner_level,
                  output oven_mode, output oven_level, output fan_level,
                  input ready);
  modport sink   (input valid, input enable_switches, input burner_level,
                  input oven_mode, input oven_level, input fan_level,
                  output ready);
endinterface

interface scce_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] target_kind;
  logic [1:0] unit_index;
  logic [2:0] action;
  logic [2:0] value;
  logic       last_of_run;

  modport source (output valid, output target_kind, output unit_index,
                  output action, output value, output last_of_run,
                  input ready);
  modport sink   (input valid, input target_kind, input unit_index,
                  input action, input value, input last_of_run,
                  output ready);
endinterface

// File: rtl/switch_change_command_emitter_core.sv
// ----------------------------------------------------------------------------
// switch_change_command_emitter_core
// Compares each cooktop panel sample with the previous one and emits the
// resulting ordered run of burner, oven and fan commands.
// ----------------------------------------------------------------------------
// Usage: a panel sample word enters on sample_i; the commands it causes leave
// one word at a time on cmd_o, in order, with last_of_run set on the final
// word of the run. A sample that changes nothing yields no word at all.
// sample_i.ready is high only while the sequencer is idle. After a sample is
// accepted, the sequencer walks a fixed list of checks, one per cycle unless stalled:
// the burner edges, the burner level commands, the oven edge with its on
// sequence, the oven mode and level changes, the fan change, and a final
// flush step. Every compare in these checks uses the same single field
// compare unit. Each command is held back until the next one appears, so
// that the last one can be marked.
// A stalled cmd_o halts the sequencer only when a new word must move into
// the held output register; the finished word waits there and the next
// sample can be accepted while it is still waiting.
// Reset clears the stored previous sample to zero and drops any run in
// progress.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module switch_change_command_emitter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  scce_sample_if.sink        sample_i,
  scce_cmd_if.source         cmd_o
);

  localparam logic [1:0] LAST_BURNER = 2'(scce_pkg::NUM_BURNERS - 1);

  scce_pkg::state_e  state_q, state_d;
  logic [1:0]        bidx_q, bidx_d;
  scce_pkg::sample_t cur_q, prev_q;
  scce_pkg::cmd_t    pend_q, pend_d;
  logic              pend_v_q, pend_v_d;
  scce_pkg::cmd_t    out_q, out_d;
  logic              out_v_q, out_v_d;

  scce_pkg::sample_t in_sample;
  scce_pkg::cmd_t    new_cmd;
  logic              accept;
  logic              emit;
  logic              flush;
  logic              push;
  logic              out_free;
  logic              stall;
  logic [2:0]        cmp_a, cmp_b;
  logic              diff;
  logic [3:0]        cur_burn, prev_burn;
  logic              oven_now;

  assign in_sample = '{enable_switches: sample_i.enable_switches,
                       burner_level:    sample_i.burner_level,
                       oven_mode:       sample_i.oven_mode,
                       oven_level:      sample_i.oven_level,
                       fan_level:       sample_i.fan_level};

  assign sample_i.ready = (state_q == scce_pkg::ST_IDLE);
  assign accept         = sample_i.valid && sample_i.ready;

  assign cur_burn  = cur_q.enable_switches[scce_pkg::MAX_BURNERS-1:0];
  assign prev_burn = prev_q.enable_switches[scce_pkg::MAX_BURNERS-1:0];
  assign oven_now  = cur_q.enable_switches[scce_pkg::OVEN_BIT];

  // The shared compare unit: the sequencer picks which field pair it sees.
  assign diff = (cmp_a != cmp_b);

  assign out_free = !out_v_q || cmd_o.ready;
  assign push     = pend_v_q && (emit || flush);
  assign stall    = push && !out_free;

  always_comb begin
    state_d = state_q;
    bidx_d  = bidx_q;
    emit    = 1'b0;
    flush   = 1'b0;
    cmp_a   = 3'd0;
    cmp_b   = 3'd0;
    new_cmd = '{target_kind: scce_pkg::KIND_BURNER, unit_index: bidx_q,
                action: scce_pkg::ACT_ON, value: 3'd0, last_of_run: 1'b0};

    unique case (state_q)
      scce_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = scce_pkg::ST_BEDGE;
          bidx_d  = 2'd0;
        end
      end
      scce_pkg::ST_BEDGE: begin
        cmp_a = {2'b00, cur_burn[bidx_q]};
        cmp_b = {2'b00, prev_burn[bidx_q]};
        emit  = diff;
        if (cur_burn[bidx_q]) begin
          new_cmd.action = scce_pkg::ACT_ON;
          new_cmd.value  = cur_q.burner_level;
        end else begin
          new_cmd.action = scce_pkg::ACT_OFF;
        end
        if (bidx_q == LAST_BURNER) begin
          state_d = scce_pkg::ST_BTEMP;
          bidx_d  = 2'd0;
        end else begin
          bidx_d = bidx_q + 2'd1;
        end
      end
      scce_pkg::ST_BTEMP: begin
        cmp_a          = cur_q.burner_level;
        cmp_b          = prev_q.burner_level;
        emit           = diff && cur_burn[bidx_q];
        new_cmd.action = scce_pkg::ACT_TEMP;
        new_cmd.value  = cur_q.burner_level;
        if (bidx_q == LAST_BURNER) begin
          state_d = scce_pkg::ST_OVEN_EDGE;
          bidx_d  = 2'd0;
        end else begin
          bidx_d = bidx_q + 2'd1;
        end
      end
      scce_pkg::ST_OVEN_EDGE: begin
        cmp_a               = {2'b00, oven_now};
        cmp_b               = {2'b00, prev_q.enable_switches[scce_pkg::OVEN_BIT]};
        emit                = diff;
        new_cmd.target_kind = scce_pkg::KIND_OVEN;
        new_cmd.unit_index  = 2'd0;
        new_cmd.action      = oven_now ? scce_pkg::ACT_ON : scce_pkg::ACT_OFF;
        state_d = (diff && oven_now) ? scce_pkg::ST_SEQ_FUNC : scce_pkg::ST_OVEN_FUNC;
      end
      scce_pkg::ST_SEQ_FUNC: begin
        emit                = 1'b1;
        new_cmd.target_kind = scce_pkg::KIND_OVEN;
        new_cmd.unit_index  = 2'd0;
        new_cmd.action      = scce_pkg::ACT_FUNC;
        new_cmd.value       = cur_q.oven_mode;
        state_d             = scce_pkg::ST_SEQ_TEMP;
      end
      scce_pkg::ST_SEQ_TEMP: begin
        emit                = 1'b1;
        new_cmd.target_kind = scce_pkg::KIND_OVEN;
        new_cmd.unit_index  = 2'd0;
        new_cmd.action      = scce_pkg::ACT_TEMP;
        new_cmd.value       = cur_q.oven_level;
        state_d             = scce_pkg::ST_OVEN_FUNC;
      end
      scce_pkg::ST_OVEN_FUNC: begin
        cmp_a               = cur_q.oven_mode;
        cmp_b               = prev_q.oven_mode;
        emit                = diff && oven_now;
        new_cmd.target_kind = scce_pkg::KIND_OVEN;
        new_cmd.unit_index  = 2'd0;
        new_cmd.action      = scce_pkg::ACT_FUNC;
        new_cmd.value       = cur_q.oven_mode;
        state_d             = scce_pkg::ST_OVEN_TEMP;
      end
      scce_pkg::ST_OVEN_TEMP: begin
        cmp_a               = cur_q.oven_level;
        cmp_b               = prev_q.oven_level;
        emit                = diff && oven_now;
        new_cmd.target_kind = scce_pkg::KIND_OVEN;
        new_cmd.unit_index  = 2'd0;
        new_cmd.action      = scce_pkg::ACT_TEMP;
        new_cmd.value       = cur_q.oven_level;
        state_d             = scce_pkg::ST_FAN;
      end
      scce_pkg::ST_FAN: begin
        cmp_a               = cur_q.fan_level;
        cmp_b               = prev_q.fan_level;
        emit                = diff;
        new_cmd.target_kind = scce_pkg::KIND_FAN;
        new_cmd.unit_index  = 2'd0;
        new_cmd.action      = scce_pkg::ACT_FAN;
        new_cmd.value       = cur_q.fan_level;
        state_d             = scce_pkg::ST_FLUSH;
      end
      scce_pkg::ST_FLUSH: begin
        flush   = 1'b1;
        state_d = scce_pkg::ST_IDLE;
      end
      default: begin
        state_d = scce_pkg::ST_IDLE;
      end
    endcase

    // A word that must move into a full output register holds the sequencer.
    if (stall) begin
      state_d = state_q;
      bidx_d  = bidx_q;
    end
  end

  // The held-back word is released when the next word appears or, marked as
  // the last one, in the flush step.
  always_comb begin
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q && !cmd_o.ready;
    if (!stall) begin
      if (push) begin
        out_d             = pend_q;
        out_d.last_of_run = flush;
        out_v_d           = 1'b1;
      end
      if (emit) begin
        pend_d   = new_cmd;
        pend_v_d = 1'b1;
      end else if (flush) begin
        pend_v_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= scce_pkg::ST_IDLE;
      bidx_q   <= 2'd0;
      cur_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      bidx_q   <= bidx_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (accept) begin
        cur_q <= in_sample;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    if (accept) begin
      prev_q <= cur_q;
    end
  end

  assign cmd_o.valid       = out_v_q;
  assign cmd_o.target_kind = out_q.target_kind;
  assign cmd_o.unit_index  = out_q.unit_index;
  assign cmd_o.action      = out_q.action;
  assign cmd_o.value       = out_q.value;
  assign cmd_o.last_of_run = out_q.last_of_run;

  // No word may be held back once the sequencer is idle again.
  `SCCE_NEVER(a_idle_no_pending, (state_q == scce_pkg::ST_IDLE) && pend_v_q)
  // An accepted sample always starts its run at the first burner.
  `SCCE_ASSERT(a_start_at_burner0,
               accept |=> (state_q == scce_pkg::ST_BEDGE) && (bidx_q == 2'd0))
  // The burner index never leaves the configured burner range.
  `SCCE_ASSERT(a_burner_idx_range,
               ((state_q == scce_pkg::ST_BEDGE) || (state_q == scce_pkg::ST_BTEMP))
               |-> ({1'b0, bidx_q} <= {1'b0, LAST_BURNER}))
  // A word released in the flush step is always marked as the last one.
  `SCCE_ASSERT(a_flush_marks_last,
               (flush && pend_v_q && !stall) |=> (out_v_q && out_q.last_of_run))

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cooktop panel command emitter. Panel samples
// are driven through a valid/ready source with random gaps, and the command
// words are taken by a sink that stalls at random. A shadow copy of the
// previous sample predicts the ordered command run of every accepted sample,
// and each received word is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int CALM_TAIL    = 40;
  localparam int DRAIN_CYCLES = 40;

  logic clk_i;
  logic rst_ni;

  scce_sample_if sample_if ();
  scce_cmd_if    cmd_if ();

  switch_change_command_emitter_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .cmd_o    (cmd_if)
  );

  scce_pkg::sample_t pending_samples[$];
  scce_pkg::cmd_t    expected_cmds[$];
  int                errors;

  // Shadow of the panel state the block compares against.
  logic [4:0] last_switches;
  logic [2:0] last_burner_level;
  logic [2:0] last_oven_mode;
  logic [2:0] last_oven_level;
  logic [2:0] last_fan_level;

  logic              sample_fire;
  int                src_gap;
  int                sink_gap;
  scce_pkg::sample_t next_sample;
  scce_pkg::sample_t seen_sample;
  scce_pkg::cmd_t    want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni                    = 1'b0;
    sample_if.valid           = 1'b0;
    sample_if.enable_switches = '0;
    sample_if.burner_level    = '0;
    sample_if.oven_mode       = '0;
    sample_if.oven_level      = '0;
    sample_if.fan_level       = '0;
    cmd_if.ready              = 1'b0;
    sample_fire               = 1'b0;
    src_gap                   = 0;
    sink_gap                  = 0;
    errors                    = 0;
    last_switches             = '0;
    last_burner_level         = '0;
    last_oven_mode            = '0;
    last_oven_level           = '0;
    last_fan_level            = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic scce_pkg::cmd_t make_cmd(scce_pkg::kind_e k, int unit,
                                              scce_pkg::action_e act, logic [2:0] val);
    scce_pkg::cmd_t c;
    c.target_kind = k;
    c.unit_index  = unit[1:0];
    c.action      = act;
    c.value       = val;
    c.last_of_run = 1'b0;
    return c;
  endfunction

  // Works out the command run of one accepted sample and updates the shadow.
  function automatic void predict_commands(scce_pkg::sample_t s);
    scce_pkg::cmd_t run[$];
    scce_pkg::cmd_t tail;
    logic oven_now;
    logic oven_was;
    oven_now = s.enable_switches[scce_pkg::OVEN_BIT];
    oven_was = last_switches[scce_pkg::OVEN_BIT];
    for (int i = 0; i < scce_pkg::NUM_BURNERS; i++) begin
      if (s.enable_switches[i] != last_switches[i]) begin
        if (s.enable_switches[i]) begin
          run.push_back(make_cmd(scce_pkg::KIND_BURNER, i, scce_pkg::ACT_ON,
                                 s.burner_level));
        end else begin
          run.push_back(make_cmd(scce_pkg::KIND_BURNER, i, scce_pkg::ACT_OFF, 3'd0));
        end
      end
    end
    if (s.burner_level != last_burner_level) begin
      for (int i = 0; i < scce_pkg::NUM_BURNERS; i++) begin
        if (s.enable_switches[i]) begin
          run.push_back(make_cmd(scce_pkg::KIND_BURNER, i, scce_pkg::ACT_TEMP,
                                 s.burner_level));
        end
      end
    end
    if (oven_now != oven_was) begin
      if (oven_now) begin
        run.push_back(make_cmd(scce_pkg::KIND_OVEN, 0, scce_pkg::ACT_ON, 3'd0));
        run.push_back(make_cmd(scce_pkg::KIND_OVEN, 0, scce_pkg::ACT_FUNC, s.oven_mode));
        run.push_back(make_cmd(scce_pkg::KIND_OVEN, 0, scce_pkg::ACT_TEMP, s.oven_level));
      end else begin
        run.push_back(make_cmd(scce_pkg::KIND_OVEN, 0, scce_pkg::ACT_OFF, 3'd0));
      end
    end
    // Mode and level changes follow even right after the on sequence.
    if (oven_now) begin
      if (s.oven_mode != last_oven_mode) begin
        run.push_back(make_cmd(scce_pkg::KIND_OVEN, 0, scce_pkg::ACT_FUNC, s.oven_mode));
      end
      if (s.oven_level != last_oven_level) begin
        run.push_back(make_cmd(scce_pkg::KIND_OVEN, 0, scce_pkg::ACT_TEMP, s.oven_level));
      end
    end
    if (s.fan_level != last_fan_level) begin
      run.push_back(make_cmd(scce_pkg::KIND_FAN, 0, scce_pkg::ACT_FAN, s.fan_level));
    end
    if (run.size() > 0) begin
      tail = run.pop_back();
      tail.last_of_run = 1'b1;
      run.push_back(tail);
    end
    foreach (run[i]) expected_cmds.push_back(run[i]);
    last_switches     = s.enable_switches;
    last_burner_level = s.burner_level;
    last_oven_mode    = s.oven_mode;
    last_oven_level   = s.oven_level;
    last_fan_level    = s.fan_level;
  endfunction

  function automatic void add_sample(logic [4:0] sw, logic [2:0] bl, logic [2:0] om,
                                     logic [2:0] ol, logic [2:0] fl);
    scce_pkg::sample_t s;
    s.enable_switches = sw;
    s.burner_level    = bl;
    s.oven_mode       = om;
    s.oven_level      = ol;
    s.fan_level       = fl;
    pending_samples.push_back(s);
  endfunction

  // Panels change slowly, so most random samples are small edits of the last.
  function automatic scce_pkg::sample_t vary_sample(scce_pkg::sample_t base);
    scce_pkg::sample_t s;
    int                pick;
    int                b;
    s    = base;
    pick = $urandom_range(0, 9);
    if (pick <= 1) begin
      s = base;
    end else if (pick <= 5) begin
      b = $urandom_range(0, 4);
      s.enable_switches[b] = ~s.enable_switches[b];
      if ($urandom_range(0, 2) == 0) s.burner_level = 3'($urandom_range(0, 7));
    end else if (pick <= 7) begin
      case ($urandom_range(0, 3))
        0: s.burner_level = 3'($urandom_range(0, 7));
        1: s.oven_mode    = 3'($urandom_range(0, 7));
        2: s.oven_level   = 3'($urandom_range(0, 7));
        default: s.fan_level = 3'($urandom_range(0, 7));
      endcase
    end else if (pick == 8) begin
      s = scce_pkg::sample_t'(17'($urandom()));
    end else begin
      s.enable_switches = s.enable_switches ^ 5'($urandom_range(0, 31));
      s.oven_mode       = 3'($urandom_range(0, 7));
      s.oven_level      = 3'($urandom_range(0, 7));
    end
    return s;
  endfunction

  // Sample source: holds a word until it is taken, with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sample_if.valid && !sample_fire) begin
        // Word still waiting for acceptance.
      end else if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        sample_if.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        if (pending_samples.size() >= CALM_TAIL && $urandom_range(0, 3) == 0) begin
          src_gap <= $urandom_range(0, 3);
          sample_if.valid <= 1'b0;
        end else begin
          next_sample = pending_samples.pop_front();
          sample_if.enable_switches <= next_sample.enable_switches;
          sample_if.burner_level    <= next_sample.burner_level;
          sample_if.oven_mode       <= next_sample.oven_mode;
          sample_if.oven_level      <= next_sample.oven_level;
          sample_if.fan_level       <= next_sample.fan_level;
          sample_if.valid           <= 1'b1;
        end
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // Command sink: random stall bursts, none near the end of the run.
  always @(negedge clk_i) begin
    if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      cmd_if.ready <= 1'b0;
    end else if (rst_ni && pending_samples.size() >= CALM_TAIL &&
                 $urandom_range(0, 5) == 0) begin
      sink_gap <= $urandom_range(0, 3);
      cmd_if.ready <= 1'b0;
    end else begin
      cmd_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_fire <= 1'b0;
    end else begin
      sample_fire <= sample_if.valid && sample_if.ready;
      if (sample_if.valid && sample_if.ready) begin
        seen_sample.enable_switches = sample_if.enable_switches;
        seen_sample.burner_level    = sample_if.burner_level;
        seen_sample.oven_mode       = sample_if.oven_mode;
        seen_sample.oven_level      = sample_if.oven_level;
        seen_sample.fan_level       = sample_if.fan_level;
        predict_commands(seen_sample);
      end
      if (cmd_if.valid && cmd_if.ready) begin
        if (expected_cmds.size() == 0) begin
          $error("unexpected command word: kind %0d unit %0d action %0d value %0d",
                 cmd_if.target_kind, cmd_if.unit_index, cmd_if.action, cmd_if.value);
          errors++;
        end else begin
          want = expected_cmds.pop_front();
          if (cmd_if.target_kind !== want.target_kind) begin
            $error("target_kind: expected %0d, got %0d", want.target_kind, cmd_if.target_kind);
            errors++;
          end
          if (cmd_if.unit_index !== want.unit_index) begin
            $error("unit_index: expected %0d, got %0d", want.unit_index, cmd_if.unit_index);
            errors++;
          end
          if (cmd_if.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, cmd_if.action);
            errors++;
          end
          if (cmd_if.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, cmd_if.value);
            errors++;
          end
          if (cmd_if.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                   cmd_if.last_of_run);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    scce_pkg::sample_t walk;
    // Nothing changed from the reset state.
    add_sample(5'h00, 3'd0, 3'd0, 3'd0, 3'd0);
    // Everything switched on at top levels: the longest possible run.
    add_sample(5'h1F, 3'd7, 3'd7, 3'd7, 3'd7);
    add_sample(5'h1F, 3'd7, 3'd7, 3'd7, 3'd7);
    // Everything off and back to zero.
    add_sample(5'h00, 3'd0, 3'd0, 3'd0, 3'd0);
    // Burner level moves with no burner enabled.
    add_sample(5'h00, 3'd3, 3'd0, 3'd0, 3'd0);
    // Oven on with unchanged mode and level, then mode and level changes.
    add_sample(5'h10, 3'd3, 3'd0, 3'd0, 3'd0);
    add_sample(5'h10, 3'd3, 3'd5, 3'd0, 3'd0);
    add_sample(5'h10, 3'd3, 3'd5, 3'd6, 3'd0);
    // Mode and level changes while the oven goes off are not reported.
    add_sample(5'h00, 3'd3, 3'd2, 3'd1, 3'd0);
    // Oven on together with new mode and level repeats them.
    add_sample(5'h10, 3'd3, 3'd4, 3'd7, 3'd0);
    // Single burners on and off, with level changes.
    add_sample(5'h11, 3'd1, 3'd4, 3'd7, 3'd0);
    add_sample(5'h12, 3'd2, 3'd4, 3'd7, 3'd0);
    add_sample(5'h14, 3'd2, 3'd4, 3'd7, 3'd0);
    add_sample(5'h08, 3'd5, 3'd4, 3'd7, 3'd0);
    add_sample(5'h0A, 3'd0, 3'd4, 3'd7, 3'd0);
    // Fan alone.
    add_sample(5'h0A, 3'd0, 3'd4, 3'd7, 3'd7);
    add_sample(5'h0A, 3'd0, 3'd4, 3'd7, 3'd1);
    add_sample(5'h15, 3'd6, 3'd0, 3'd0, 3'd0);
    add_sample(5'h00, 3'd6, 3'd0, 3'd0, 3'd0);

    walk = pending_samples[$];
    repeat (241) begin
      walk = vary_sample(walk);
      pending_samples.push_back(walk);
    end

    @(posedge rst_ni);
    while (pending_samples.size() != 0 || sample_if.valid || expected_cmds.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
